// ----- rtl/gdb_pkg.sv -----
// Shared types and constants of the Gershgorin disc bounds unit.
// No dependencies; used by gdb_row_accum, gdb_disc_stats and the top level.
package gdb_pkg;

    localparam int ElemW   = 32;
    localparam int RadiusW = 39;
    localparam int EdgeW   = 40;
    localparam int WideW   = 41;
    localparam int RowIdxW = 6;
    localparam int SizeW   = 7;

    localparam logic signed [WideW-1:0] WIDE_MAX = {1'b0, {(WideW-1){1'b1}}};
    localparam logic signed [WideW-1:0] WIDE_MIN = {1'b1, {(WideW-1){1'b0}}};
    localparam logic signed [EdgeW-1:0] EDGE_MAX = {1'b0, {(EdgeW-1){1'b1}}};
    localparam logic signed [EdgeW-1:0] EDGE_MIN = {1'b1, {(EdgeW-1){1'b0}}};
    localparam logic [RadiusW-1:0]      RADIUS_MAX = {RadiusW{1'b1}};

    // One finished row, handed from the accumulator to the disc evaluation.
    typedef struct packed {
        logic [RowIdxW-1:0]       row_index;
        logic signed [ElemW-1:0]  center;
        logic [RadiusW-1:0]       radius;
        logic                     last_row;
    } row_t;

    typedef struct packed {
        logic [RowIdxW-1:0]       row_index;
        logic signed [ElemW-1:0]  center;
        logic [RadiusW-1:0]       radius;
        logic signed [EdgeW-1:0]  lower_edge;
        logic signed [EdgeW-1:0]  upper_edge;
        logic                     disc_has_zero;
        logic signed [EdgeW-1:0]  bound_low;
        logic signed [EdgeW-1:0]  bound_high;
        logic [RadiusW-1:0]       spectral_bound;
        logic                     any_disc_has_zero;
        logic                     all_discs_positive;
        logic                     last_row;
    } result_t;

endpackage

// ----- rtl/gershgorin_disc_bounds_unit.sv -----
// Top level of the Gershgorin disc bounds unit: stream ports and packing.
// Depends on gdb_pkg, gdb_row_accum and gdb_disc_stats.
//
// Matrix elements (signed Q16.16) enter in row-major order, one per cycle at full rate
// while s_tready is high; each row's last element produces one result, through the row
// and output registers, carrying that row's disc and the running bounds over the rows so far. The
// element path is a single 40-bit saturating add into the row register; the
// disc evaluation then runs from the row register into the output register.
// With m_tready low the two registers hold two rows before s_tready drops.
// A write on the cfg channel sets the matrix size (0 acts as 1,
// values above MAX_SIZE act as MAX_SIZE) and restarts the matrix; write it
// only while no request is in flight. m_tlast marks the final row, whose
// running figures are the matrix's bounds.
module gershgorin_disc_bounds_unit #(
    parameter int MAX_SIZE = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data,    // matrix_size
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,     // element_value[31:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_index[5:0], center[37:6], radius[76:38], lower_edge[116:77],
    // upper_edge[156:117], disc_has_zero[157], bound_low[197:158],
    // bound_high[237:198], spectral_bound[276:238], any_disc_has_zero[277],
    // all_discs_positive[278], zero pad[279]
    output logic [279:0] m_tdata,
    output logic         m_tlast      // last_row
);

    logic             restart;
    logic             row_valid, row_ready;
    gdb_pkg::row_t    row_data;
    gdb_pkg::result_t result;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && cfg_ready;

    gdb_row_accum #(
        .MAX_SIZE (MAX_SIZE)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .size_value (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_elem    ($signed(s_tdata)),
        .row_valid  (row_valid),
        .row_ready  (row_ready),
        .row_data   (row_data)
    );

    gdb_disc_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .in_valid   (row_valid),
        .in_ready   (row_ready),
        .in_row     (row_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {1'b0,
                      result.all_discs_positive,
                      result.any_disc_has_zero,
                      result.spectral_bound,
                      result.bound_high,
                      result.bound_low,
                      result.disc_has_zero,
                      result.upper_edge,
                      result.lower_edge,
                      result.radius,
                      result.center,
                      result.row_index};
    assign m_tlast = result.last_row;

endmodule

// ----- rtl/gdb_row_accum.sv -----
// Row accumulator: column/row counters, diagonal capture, saturating radius sum.
// Depends on gdb_pkg; emits one gdb_pkg::row_t request per finished row.
module gdb_row_accum #(
    parameter int MAX_SIZE = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      restart,
    input  logic [gdb_pkg::SizeW-1:0] size_value,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [gdb_pkg::ElemW-1:0] in_elem,
    output logic                      row_valid,
    input  logic                      row_ready,
    output gdb_pkg::row_t             row_data
);

    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW = CW + 1;
    localparam int CMPW = 10;

    logic [SW-1:0]                   size_reg, size_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [CW-1:0]                   row_reg, row_next;
    logic signed [gdb_pkg::ElemW-1:0] center_reg, center_next;
    logic [gdb_pkg::RadiusW-1:0]     radius_reg, radius_next;
    logic                            row_valid_reg, row_valid_next;
    gdb_pkg::row_t                   row_data_reg, row_data_next;

    logic [CMPW-1:0]                 size_wide;
    logic [gdb_pkg::ElemW-1:0]       mag;
    logic [gdb_pkg::RadiusW:0]       sum;
    logic                            accept, is_diag, row_end, last;
    logic signed [gdb_pkg::ElemW-1:0] center_upd;
    logic [gdb_pkg::RadiusW-1:0]     radius_upd;

    assign in_ready  = !row_valid_reg || row_ready;
    assign accept    = in_valid && in_ready;
    assign row_valid = row_valid_reg;
    assign row_data  = row_data_reg;

    always_comb begin
        size_wide = {{(CMPW-gdb_pkg::SizeW){1'b0}}, size_value};
        if (size_wide == '0) begin
            size_wide = CMPW'(1);
        end else if (size_wide > CMPW'(MAX_SIZE)) begin
            size_wide = CMPW'(MAX_SIZE);
        end
    end

    always_comb begin
        mag = in_elem[gdb_pkg::ElemW-1] ? (~in_elem + gdb_pkg::ElemW'(1)) : in_elem;
        sum = {1'b0, radius_reg} + (gdb_pkg::RadiusW+1)'(mag);
        is_diag = (col_reg == row_reg);
        center_upd = is_diag ? in_elem : center_reg;
        if (is_diag) begin
            radius_upd = radius_reg;
        end else if (sum[gdb_pkg::RadiusW]) begin
            radius_upd = gdb_pkg::RADIUS_MAX;
        end else begin
            radius_upd = sum[gdb_pkg::RadiusW-1:0];
        end
        row_end = !(({1'b0, col_reg} + SW'(1)) < size_reg);
        last    = !(({1'b0, row_reg} + SW'(1)) < size_reg);
    end

    always_comb begin
        size_next      = size_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        center_next    = center_reg;
        radius_next    = radius_reg;
        row_valid_next = row_valid_reg && !row_ready;
        row_data_next  = row_data_reg;
        if (restart) begin
            size_next   = size_wide[SW-1:0];
            col_next    = '0;
            row_next    = '0;
            center_next = '0;
            radius_next = '0;
        end else if (accept) begin
            if (row_end) begin
                row_valid_next          = 1'b1;
                row_data_next.row_index = gdb_pkg::RowIdxW'(row_reg);
                row_data_next.center    = center_upd;
                row_data_next.radius    = radius_upd;
                row_data_next.last_row  = last;
                col_next    = '0;
                row_next    = last ? '0 : row_reg + CW'(1);
                center_next = '0;
                radius_next = '0;
            end else begin
                col_next    = col_reg + CW'(1);
                center_next = center_upd;
                radius_next = radius_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= SW'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            center_reg    <= '0;
            radius_reg    <= '0;
            row_valid_reg <= 1'b0;
        end else begin
            size_reg      <= size_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            center_reg    <= center_next;
            radius_reg    <= radius_next;
            row_valid_reg <= row_valid_next;
        end
        row_data_reg <= row_data_next;
    end

endmodule

// ----- rtl/gdb_disc_stats.sv -----
// Disc evaluation: edges, zero test, spectral term and running figures per matrix.
// Depends on gdb_pkg; consumes gdb_pkg::row_t, holds the gdb_pkg::result_t output register.
module gdb_disc_stats (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdb_pkg::row_t     in_row,
    output logic              out_valid,
    input  logic              out_ready,
    output gdb_pkg::result_t  out_result
);

    logic signed [gdb_pkg::WideW-1:0] least_reg, least_next;
    logic signed [gdb_pkg::WideW-1:0] great_reg, great_next;
    logic [gdb_pkg::RadiusW-1:0]      spec_reg, spec_next;
    logic                             zero_reg, zero_next;
    logic                             pos_reg, pos_next;
    logic                             out_valid_reg, out_valid_next;
    gdb_pkg::result_t                 result_reg, result_next;

    logic                             accept;
    logic [gdb_pkg::ElemW-1:0]        cmag;
    logic signed [gdb_pkg::WideW-1:0] center_w, radius_w, lower_w, upper_w;
    logic signed [gdb_pkg::EdgeW-1:0] lower, upper;
    logic [gdb_pkg::RadiusW:0]        spec_sum;
    logic [gdb_pkg::RadiusW-1:0]      spec;
    logic                             has_zero;
    logic signed [gdb_pkg::WideW-1:0] least_upd, great_upd;
    logic [gdb_pkg::RadiusW-1:0]      spec_upd;
    logic                             zero_upd, pos_upd;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb begin
        cmag = in_row.center[gdb_pkg::ElemW-1] ? (~in_row.center + gdb_pkg::ElemW'(1))
                                               : in_row.center;
        center_w = gdb_pkg::WideW'(in_row.center);
        radius_w = $signed({2'b00, in_row.radius});
        lower_w  = center_w - radius_w;
        upper_w  = center_w + radius_w;
        if (lower_w[gdb_pkg::WideW-1] != lower_w[gdb_pkg::EdgeW-1]) begin
            lower = lower_w[gdb_pkg::WideW-1] ? gdb_pkg::EDGE_MIN : gdb_pkg::EDGE_MAX;
        end else begin
            lower = lower_w[gdb_pkg::EdgeW-1:0];
        end
        if (upper_w[gdb_pkg::WideW-1] != upper_w[gdb_pkg::EdgeW-1]) begin
            upper = upper_w[gdb_pkg::WideW-1] ? gdb_pkg::EDGE_MIN : gdb_pkg::EDGE_MAX;
        end else begin
            upper = upper_w[gdb_pkg::EdgeW-1:0];
        end
        spec_sum = {1'b0, in_row.radius} + (gdb_pkg::RadiusW+1)'(cmag);
        spec     = spec_sum[gdb_pkg::RadiusW] ? gdb_pkg::RADIUS_MAX
                                              : spec_sum[gdb_pkg::RadiusW-1:0];
        has_zero = ((gdb_pkg::RadiusW)'(cmag) <= in_row.radius);

        least_upd = (gdb_pkg::WideW'(lower) < least_reg) ? gdb_pkg::WideW'(lower) : least_reg;
        great_upd = (gdb_pkg::WideW'(upper) > great_reg) ? gdb_pkg::WideW'(upper) : great_reg;
        spec_upd  = (spec > spec_reg) ? spec : spec_reg;
        zero_upd  = zero_reg || has_zero;
        pos_upd   = pos_reg && (lower > 0);
    end

    always_comb begin
        least_next     = least_reg;
        great_next     = great_reg;
        spec_next      = spec_reg;
        zero_next      = zero_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        if (restart) begin
            least_next = gdb_pkg::WIDE_MAX;
            great_next = gdb_pkg::WIDE_MIN;
            spec_next  = '0;
            zero_next  = 1'b0;
            pos_next   = 1'b1;
        end else if (accept) begin
            out_valid_next                 = 1'b1;
            result_next.row_index          = in_row.row_index;
            result_next.center             = in_row.center;
            result_next.radius             = in_row.radius;
            result_next.lower_edge         = lower;
            result_next.upper_edge         = upper;
            result_next.disc_has_zero      = has_zero;
            result_next.bound_low          = least_upd[gdb_pkg::EdgeW-1:0];
            result_next.bound_high         = great_upd[gdb_pkg::EdgeW-1:0];
            result_next.spectral_bound     = spec_upd;
            result_next.any_disc_has_zero  = zero_upd;
            result_next.all_discs_positive = pos_upd;
            result_next.last_row           = in_row.last_row;
            if (in_row.last_row) begin
                least_next = gdb_pkg::WIDE_MAX;
                great_next = gdb_pkg::WIDE_MIN;
                spec_next  = '0;
                zero_next  = 1'b0;
                pos_next   = 1'b1;
            end else begin
                least_next = least_upd;
                great_next = great_upd;
                spec_next  = spec_upd;
                zero_next  = zero_upd;
                pos_next   = pos_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            least_reg     <= gdb_pkg::WIDE_MAX;
            great_reg     <= gdb_pkg::WIDE_MIN;
            spec_reg      <= '0;
            zero_reg      <= 1'b0;
            pos_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            least_reg     <= least_next;
            great_reg     <= great_next;
            spec_reg      <= spec_next;
            zero_reg      <= zero_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
        result_reg <= result_next;
    end

endmodule
